### rtl/ilmw_pkg.sv
// shared types and constants for the indexed list move and walk block
package ilmw_pkg;

	localparam int ELEM_W = 7;

	typedef logic [ELEM_W-1:0] elem_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_INIT = 6'b000010,
		ST_MV1  = 6'b000100,
		ST_MV2  = 6'b001000,
		ST_MV3  = 6'b010000,
		ST_QRY  = 6'b100000
	} state_t;

	localparam logic CMD_MOVE  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

endpackage

### rtl/ilmw_ram.sv
// generic single write port ram with registered read
module ilmw_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/indexed_list_move_and_walk.sv
// top level of the indexed list move and walk block
//
// Keeps a permutation of 1..list_size as a circular doubly linked list in two
// rams (next and prev links, slot 0 is the sentinel).
// Command channel: a word is taken when start is high and busy is low.
//   cmd = move: unlink elem and relink it after anchor, no result; busy
//   through the steps unlink, link after anchor and close (both rams
//   written in each step, links of elem read at the taking edge).
//   An out-of-range or self move is dropped at once and busy stays low.
//   cmd = query: walks from the head, one next-link read per cycle, and emits
//   list_size words on value/last, each marked by strobe for one cycle, last
//   set on the final one.
// Config channel: list_size is written when cfg_valid and cfg_ready are high,
//   ready only while idle and start is low; a size of 0 is taken as 1, above
//   MAX_ELEMS as MAX_ELEMS.
// After reset and after every size write the links are rebuilt in order,
//   one entry per cycle, entries 0 to list_size (0 to MAX_ELEMS after
//   reset).
// The receiver cannot stall; words are produced at one per cycle at most.
module indexed_list_move_and_walk #(
	parameter int MAX_ELEMS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cmd,
	input  ilmw_pkg::elem_t      elem,
	input  ilmw_pkg::elem_t      anchor,
	output logic                 strobe,
	output ilmw_pkg::elem_t      value,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  ilmw_pkg::elem_t      list_size
);

	import ilmw_pkg::*;

	localparam int DEPTH = MAX_ELEMS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam elem_t MAX_E = elem_t'(MAX_ELEMS);

	state_t state_q;
	elem_t  size_q;
	elem_t  cnt_q;
	elem_t  elem_q;
	elem_t  anchor_q;
	elem_t  p_q;
	elem_t  n_q;
	elem_t  an_q;
	elem_t  value_q;
	logic   last_q;
	logic   strobe_q;

	logic          nx_we;
	logic [AW-1:0] nx_waddr;
	elem_t         nx_wdata;
	logic [AW-1:0] nx_raddr;
	elem_t         nx_rd;
	logic          pv_we;
	logic [AW-1:0] pv_waddr;
	elem_t         pv_wdata;
	logic [AW-1:0] pv_raddr;
	elem_t         pv_rd;

	logic  accept;
	logic  cfg_wr;
	logic  move_ok;
	elem_t size_clamp;
	elem_t an_fwd;
	logic  walk_end;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign accept    = start && !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign move_ok = (elem != anchor) && (elem != '0) && (elem <= size_q)
		&& (anchor != '0) && (anchor <= size_q);

	always_comb begin
		size_clamp = list_size;
		if (list_size == '0) begin
			size_clamp = elem_t'(1);
		end else if (list_size > MAX_E) begin
			size_clamp = MAX_E;
		end
	end

	// anchor equal to the old predecessor sees the link written in the same cycle
	assign an_fwd   = (anchor_q == p_q) ? n_q : nx_rd;
	assign walk_end = (cnt_q == size_q - elem_t'(1));

	always_comb begin
		nx_we    = 1'b0;
		nx_waddr = '0;
		nx_wdata = '0;
		pv_we    = 1'b0;
		pv_waddr = '0;
		pv_wdata = '0;
		nx_raddr = AW'(elem);
		pv_raddr = AW'(elem);
		case (state_q)
			ST_IDLE: begin
				nx_raddr = (cmd == CMD_QUERY) ? '0 : AW'(elem);
			end
			ST_INIT: begin
				nx_we    = 1'b1;
				nx_waddr = AW'(cnt_q);
				nx_wdata = (cnt_q == size_q) ? '0 : cnt_q + elem_t'(1);
				pv_we    = 1'b1;
				pv_waddr = AW'(cnt_q);
				pv_wdata = (cnt_q == '0) ? size_q : cnt_q - elem_t'(1);
			end
			ST_MV1: begin
				nx_we    = 1'b1;
				nx_waddr = AW'(pv_rd);
				nx_wdata = nx_rd;
				pv_we    = 1'b1;
				pv_waddr = AW'(nx_rd);
				pv_wdata = pv_rd;
				nx_raddr = AW'(anchor_q);
			end
			ST_MV2: begin
				nx_we    = 1'b1;
				nx_waddr = AW'(anchor_q);
				nx_wdata = elem_q;
				pv_we    = 1'b1;
				pv_waddr = AW'(elem_q);
				pv_wdata = anchor_q;
			end
			ST_MV3: begin
				nx_we    = 1'b1;
				nx_waddr = AW'(elem_q);
				nx_wdata = an_q;
				pv_we    = 1'b1;
				pv_waddr = AW'(an_q);
				pv_wdata = elem_q;
			end
			ST_QRY: begin
				nx_raddr = AW'(nx_rd);
			end
			default: begin
				nx_we = 1'b0;
			end
		endcase
	end

	ilmw_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (nx_raddr),
		.rdata (nx_rd)
	);

	ilmw_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.raddr (pv_raddr),
		.rdata (pv_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			size_q   <= MAX_E;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cfg_wr) begin
						size_q  <= size_clamp;
						cnt_q   <= '0;
						state_q <= ST_INIT;
					end else if (accept) begin
						cnt_q <= '0;
						if (cmd == CMD_QUERY) begin
							state_q <= ST_QRY;
						end else if (move_ok) begin
							state_q <= ST_MV1;
						end
					end
				end
				ST_INIT: begin
					cnt_q <= cnt_q + elem_t'(1);
					if (cnt_q == size_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MV1: state_q <= ST_MV2;
				ST_MV2: state_q <= ST_MV3;
				ST_MV3: state_q <= ST_IDLE;
				ST_QRY: begin
					strobe_q <= 1'b1;
					last_q   <= walk_end;
					cnt_q    <= cnt_q + elem_t'(1);
					if (walk_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			elem_q   <= elem;
			anchor_q <= anchor;
		end
		if (state_q == ST_MV1) begin
			p_q <= pv_rd;
			n_q <= nx_rd;
		end
		if (state_q == ST_MV2) begin
			an_q <= an_fwd;
		end
		if (state_q == ST_QRY) begin
			value_q <= nx_rd;
		end
	end

	assign strobe = strobe_q;
	assign value  = value_q;
	assign last   = last_q;

`ifndef ASSERT_OFF
	a_strobe_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_QRY))
		else $error("word emitted outside a walk");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> (state_q == ST_IDLE))
		else $error("walk continues after last word");

	a_cfg_rebuilds: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (state_q == ST_INIT) && (cnt_q == '0))
		else $error("size write did not start a rebuild");

	a_move_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MV1) |=> (state_q == ST_MV2) ##1 (state_q == ST_MV3)
			##1 (state_q == ST_IDLE))
		else $error("move sequence broken");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		(size_q != '0) && (size_q <= MAX_E))
		else $error("list size out of range");
`endif

endmodule
